// ===== rtl/core/subscriber_table_fanout_assert.svh =====
// Assertion macros for the subscriber table fanout block.
`ifndef SUBSCRIBER_TABLE_FANOUT_ASSERT_SVH
`define SUBSCRIBER_TABLE_FANOUT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/stf_pkg.sv =====
// ----------------------------------------------------------------------------
// stf_pkg
// Shared types and constants of the subscriber table fanout block.
// ----------------------------------------------------------------------------
`default_nettype none

package stf_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned ENTRY_W     = ADDR_W + PORT_W;

  localparam logic [ACT_W-1:0] ACT_FORWARD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REGISTER   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEREGISTER = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/stf_ram.sv =====
// ----------------------------------------------------------------------------
// stf_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module stf_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stf_engine.sv =====
// ----------------------------------------------------------------------------
// stf_engine
// Table sequencer: append, search and compact, then walk the table and
// offer one word per entry that differs from the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module stf_engine #(
  parameter int unsigned DEPTH  = stf_pkg::TABLE_DEPTH,
  parameter int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW     = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [stf_pkg::ACT_W-1:0]    action,
  input  wire logic [stf_pkg::ADDR_W-1:0]   src_addr,
  input  wire logic [stf_pkg::PORT_W-1:0]   src_port,
  input  wire logic [stf_pkg::TAG_W-1:0]    msg_tag,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [stf_pkg::ENTRY_W-1:0]       ram_wdata,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr,
  input  wire logic [stf_pkg::ENTRY_W-1:0]  ram_rdata,
  output logic                              res_valid,
  output stf_pkg::res_t                     res,
  input  wire logic                         res_ready
);

  typedef enum logic [2:0] {
    S_IDLE, S_REG, S_SCAN, S_MV_RD, S_MV_WR, S_FAN
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 rd_idx;
  logic [AW-1:0]                 chk_idx;
  logic                          chk_vld;
  logic                          found;
  logic [AW-1:0]                 pos;
  logic                          pend_vld;
  logic [stf_pkg::ENTRY_W-1:0]   pend;
  logic [stf_pkg::ENTRY_W-1:0]   key;
  logic [stf_pkg::TAG_W-1:0]     tag;

  logic more;
  logic hit;
  logic miss;
  logic done;
  logic freeze;
  logic room;

  assign in_stall = (state != S_IDLE);
  assign more     = (rd_idx < count);
  assign hit      = chk_vld && (ram_rdata == key);
  assign miss     = chk_vld && (ram_rdata != key);
  assign done     = !chk_vld && !more;
  assign room     = (count < CW'(DEPTH));
  assign freeze   = (state == S_FAN) && miss && pend_vld && !res_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = key;
    ram_re    = 1'b0;
    ram_raddr = rd_idx[AW-1:0];
    unique case (state)
      S_REG: begin
        ram_we = room;
      end
      S_SCAN: begin
        ram_re = more;
      end
      S_MV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(count - CW'(1));
      end
      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = ram_rdata;
      end
      S_FAN: begin
        ram_re = more && !freeze;
      end
      default: begin
      end
    endcase
  end

  assign res_valid = (state == S_FAN) && pend_vld && (miss || done);
  assign res.addr  = pend[stf_pkg::ENTRY_W-1:stf_pkg::PORT_W];
  assign res.port  = pend[stf_pkg::PORT_W-1:0];
  assign res.tag   = tag;
  assign res.last  = !chk_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      chk_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            key     <= {src_addr, src_port};
            tag     <= msg_tag;
            rd_idx  <= '0;
            chk_vld <= 1'b0;
            found   <= 1'b0;
            case (action)
              stf_pkg::ACT_REGISTER:   state <= S_REG;
              stf_pkg::ACT_DEREGISTER: state <= S_SCAN;
              default:                 state <= S_FAN;
            endcase
          end
        end
        S_REG: begin
          if (room) begin
            count <= count + CW'(1);
          end
          state <= S_FAN;
        end
        S_SCAN: begin
          if (more) begin
            rd_idx  <= rd_idx + CW'(1);
            chk_idx <= rd_idx[AW-1:0];
          end
          chk_vld <= more;
          if (hit) begin
            found <= 1'b1;
            pos   <= chk_idx;
          end
          if (done) begin
            rd_idx <= '0;
            state  <= found ? S_MV_RD : S_FAN;
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          count <= count - CW'(1);
          state <= S_FAN;
        end
        S_FAN: begin
          if (!freeze) begin
            if (more) begin
              rd_idx <= rd_idx + CW'(1);
            end
            chk_vld <= more;
            if (miss) begin
              pend_vld <= 1'b1;
              pend     <= ram_rdata;
            end
          end
          if (done && (!pend_vld || res_ready)) begin
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/subscriber_table_fanout.sv =====
// ----------------------------------------------------------------------------
// subscriber_table_fanout
// Multicast replication list: subscriber table with per-message fanout.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one word: action, sender endpoint
// and message tag. A register word appends the sender unless the table is
// full; a deregister word moves the final entry into the slot of the last
// matching entry and shrinks the table. Every word then yields one output
// word (out_valid/out_stall) per stored entry that differs from the sender,
// in table order, with last_copy on the final one; none if no entry differs.
// One word is in work at a time; in_stall stays high until its last copy
// has entered the output register. The time per word grows with the number
// of stored entries, set by the single read port of the table RAM walked
// one entry per cycle while no output stall freezes the walk. A deregister
// walks the table twice, to search and then to fan out, with a read and a
// write of the moved entry between the walks when it finds the sender. An
// output stall holds the output word and freezes the walk once the next
// copy is ready. Reset empties the table at once; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module subscriber_table_fanout #(
  parameter int unsigned TABLE_DEPTH = stf_pkg::TABLE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [stf_pkg::ACT_W-1:0]   action,
  input  wire logic [stf_pkg::ADDR_W-1:0]  src_addr,
  input  wire logic [stf_pkg::PORT_W-1:0]  src_port,
  input  wire logic [stf_pkg::TAG_W-1:0]   msg_tag,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [stf_pkg::ADDR_W-1:0]       dest_addr,
  output logic [stf_pkg::PORT_W-1:0]       dest_port,
  output logic [stf_pkg::TAG_W-1:0]        out_tag,
  output logic                             last_copy
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [stf_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [stf_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                         res_valid;
  stf_pkg::res_t                res;
  logic                         res_ready;
  stf_pkg::res_t                oword;

  stf_ram #(
    .WIDTH  (stf_pkg::ENTRY_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stf_engine #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .src_addr  (src_addr),
    .src_port  (src_port),
    .msg_tag   (msg_tag),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      oword     <= res;
    end
  end

  assign dest_addr = oword.addr;
  assign dest_port = oword.port;
  assign out_tag   = oword.tag;
  assign last_copy = oword.last;

`include "subscriber_table_fanout_assert.svh"

  `STF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "offered word changed while blocked")
  `STF_ASSERT_IMPL(a_idle_quiet, !in_stall, !res_valid, "idle engine offers a word")
  `STF_ASSERT_IMPL(a_ram_excl, ram_we, !ram_re, "table RAM read and written in one cycle")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the subscriber table fanout block.
// ----------------------------------------------------------------------------
// Sends register, deregister and forward words and keeps its own copy of the
// endpoint table. From that copy it works out the list of copies that each
// accepted word must yield. Every copy that leaves the block is compared
// with the oldest one still pending. A directed opening covers these cases:
// an empty table, a full table, duplicates, misses, the spare action code and
// the all-zero and all-one endpoints. Random traffic follows in mixed,
// shrinking and growing phases. Random idle cycles on both sides, and one
// long output hold-off, fill the block so that it backs up its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stf_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int unsigned RANDOM_WORDS = 235;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  class copy_board;
    logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
    logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
    int unsigned entries;
    res_t        pending_copies[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned words;
    int unsigned full_drops;
    int unsigned removals;

    function new();
      entries = 0;
      mismatches = 0;
      checked = 0;
      words = 0;
      full_drops = 0;
      removals = 0;
    endfunction

    function bit holds(int unsigned i, logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p);
      return tbl_addr[i] == a && tbl_port[i] == p;
    endfunction

    function void note_word(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] a,
                            logic [PORT_W-1:0] p, logic [TAG_W-1:0] t);
      int   hit;
      int   n;
      int   k;
      res_t r;
      hit = -1;
      n = 0;
      k = 0;
      words++;
      if (act == ACT_REGISTER) begin
        if (entries < TABLE_DEPTH) begin
          tbl_addr[entries] = a;
          tbl_port[entries] = p;
          entries++;
        end else begin
          full_drops++;
        end
      end else if (act == ACT_DEREGISTER) begin
        for (int i = 0; i < entries; i++)
          if (holds(i, a, p)) hit = i;
        if (hit >= 0) begin
          tbl_addr[hit] = tbl_addr[entries-1];
          tbl_port[hit] = tbl_port[entries-1];
          entries--;
          removals++;
        end
      end
      for (int i = 0; i < entries; i++)
        if (!holds(i, a, p)) n++;
      for (int i = 0; i < entries; i++) begin
        if (!holds(i, a, p)) begin
          k++;
          r.addr = tbl_addr[i];
          r.port = tbl_port[i];
          r.tag  = t;
          r.last = (k == n);
          pending_copies.push_back(r);
        end
      end
    endfunction

    function void flag(string what, res_t want, res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("tb: %s: expected %h:%h tag %h last %b, got %h:%h tag %h last %b",
                 what, want.addr, want.port, want.tag, want.last,
                 got.addr, got.port, got.tag, got.last);
    endfunction

    function void check_copy(res_t got);
      res_t want;
      checked++;
      if (pending_copies.size() == 0) begin
        want = 'x;
        flag("copy with none pending", want, got);
        return;
      end
      want = pending_copies.pop_front();
      if (got.addr !== want.addr || got.port !== want.port ||
          got.tag !== want.tag || got.last !== want.last)
        flag("copy mismatch", want, got);
    endfunction

    function int unsigned pending();
      return pending_copies.size();
    endfunction
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  action    = '0;
  logic [ADDR_W-1:0] src_addr  = '0;
  logic [PORT_W-1:0] src_port  = '0;
  logic [TAG_W-1:0]  msg_tag   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] dest_addr;
  logic [PORT_W-1:0] dest_port;
  logic [TAG_W-1:0]  out_tag;
  logic              last_copy;

  bit                no_idle = 1'b0;
  logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
  logic [PORT_W-1:0] pool_port [POOL_SIZE];
  copy_board         board = new();

  subscriber_table_fanout uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .src_addr  (src_addr),
    .src_port  (src_port),
    .msg_tag   (msg_tag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dest_addr (dest_addr),
    .dest_port (dest_port),
    .out_tag   (out_tag),
    .last_copy (last_copy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // hold the word until taken, then note it
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] a,
                           input logic [PORT_W-1:0] p, input logic [TAG_W-1:0] t);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    src_addr <= a;
    src_port <= p;
    msg_tag  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(act, a, p, t);
  endtask

  task automatic send_random(input int unsigned phase);
    int unsigned      r;
    int unsigned      idx;
    logic [ACT_W-1:0] act;
    logic [ADDR_W-1:0] a;
    logic [PORT_W-1:0] p;
    r = $urandom_range(0, 99);
    case (phase)
      0: act = r < 30 ? ACT_REGISTER : r < 55 ? ACT_DEREGISTER :
               r < 93 ? ACT_FORWARD : ACT_SPARE;
      1: act = r < 12 ? ACT_REGISTER : r < 65 ? ACT_DEREGISTER :
               r < 93 ? ACT_FORWARD : ACT_SPARE;
      default: act = r < 60 ? ACT_REGISTER : r < 72 ? ACT_DEREGISTER :
                     r < 94 ? ACT_FORWARD : ACT_SPARE;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      idx = $urandom_range(0, POOL_SIZE - 1);
      a = pool_addr[idx];
      p = pool_port[idx];
    end else begin
      a = $urandom;
      p = PORT_W'($urandom);
    end
    send_word(act, a, p, TAG_W'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_copy({dest_addr, dest_port, out_tag, last_copy});
  end

  // stall the output per copy, with one long hold-off
  initial begin
    int unsigned wait_cycles;
    int unsigned taken;
    taken = 0;
    forever begin
      if (taken == HOLD_AT)
        wait_cycles = HOLD_CYCLES;
      else
        wait_cycles = no_idle ? 0 : $urandom_range(0, 13);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = PORT_W'($urandom);
      if (i % 2 == 1) pool_addr[i] = pool_addr[i-1];
      else if (i % 4 == 2) pool_port[i] = pool_port[i-1];
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(ACT_FORWARD,    32'h0,          16'h0,    8'h00);
    send_word(ACT_DEREGISTER, 32'h0,          16'h0,    8'hff);
    send_word(ACT_REGISTER,   32'h0,          16'h0,    8'h01);
    send_word(ACT_REGISTER,   32'hffff_ffff,  16'hffff, 8'h02);
    send_word(ACT_REGISTER,   32'h0,          16'h0,    8'h03);
    send_word(ACT_SPARE,      32'hc0a8_0001,  16'h1f90, 8'h04);
    send_word(ACT_DEREGISTER, 32'hc0a8_0001,  16'h1f90, 8'h05);
    send_word(ACT_DEREGISTER, 32'h0,          16'h0,    8'h06);
    send_word(ACT_DEREGISTER, 32'hffff_ffff,  16'hffff, 8'h07);
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      send_word(ACT_REGISTER, ADDR_W'(32'h0a00_0000 | i), PORT_W'(16'h8000 | i),
                TAG_W'(8'h10 + i));
    send_word(ACT_REGISTER,   32'hc0a8_0001,  16'h1f90, 8'h80);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_idle = ((n / 30) % 4) == 3;
      send_random((n / 40) % 3);
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d words sent, %0d copies checked, %0d mismatches",
             board.words, board.checked, board.mismatches);
    $display("tb: %0d appends dropped on a full table, %0d entries removed",
             board.full_drops, board.removals);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/stf_pkg.sv
rtl/core/stf_ram.sv
rtl/core/stf_engine.sv
rtl/core/subscriber_table_fanout.sv
sim/tb.sv
